FILE: src/tmgs_pkg.sv
// Shared constants and types for the topic model Gibbs sampler.
// No dependencies; the sampler module imports this package and tmgs_cfg_if uses its widths.
`default_nettype none
package tmgs_pkg;
  localparam int TOPICS     = 128;
  localparam int WORDS      = 4096;
  localparam int DOCS       = 1024;
  localparam int COUNT_BITS = 16;

  localparam int TOPIC_W = $clog2(TOPICS);
  localparam int WORD_W  = $clog2(WORDS);
  localparam int DOC_W   = $clog2(DOCS);
  localparam int WT_AW   = WORD_W + TOPIC_W;
  localparam int DT_AW   = DOC_W + TOPIC_W;

  localparam int TOT_BITS = 24;
  localparam int Q_BITS   = 24;
  localparam int W_BITS   = 48;
  localparam int FRAC     = 16;
  localparam int DEN_W    = TOT_BITS + FRAC + 1;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [TOT_BITS-1:0]   TOT_MAX = '1;
  localparam logic [Q_BITS-1:0]     Q_MAX   = '1;
  localparam logic [W_BITS-1:0]     W_MAX   = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOPIC_COUNT = 2'd0,
    REG_VOCAB_SIZE  = 2'd1,
    REG_ALPHA       = 2'd2,
    REG_BETA        = 2'd3
  } cfg_reg_t;
endpackage
`default_nettype wire

FILE: src/tmgs_in_if.sv
// Token input channel: valid/ready handshake with the token fields.
// No dependencies; the field widths are written out as literals.
`default_nettype none
interface tmgs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [9:0]  doc_index;
  logic [11:0] word_index;
  logic [6:0]  old_topic;
  logic [15:0] random_fraction;
  modport source (output valid, mode, doc_index, word_index, old_topic, random_fraction,
                  input ready);
  modport sink (input valid, mode, doc_index, word_index, old_topic, random_fraction,
                output ready);
endinterface
`default_nettype wire

FILE: src/tmgs_out_if.sv
// Result channel: valid/ready handshake with the chosen topic and error flag.
// No dependencies; the field widths are written out as literals.
`default_nettype none
interface tmgs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] new_topic;
  logic       count_error;
  modport source (output valid, new_topic, count_error, input ready);
  modport sink (input valid, new_topic, count_error, output ready);
endinterface
`default_nettype wire

FILE: src/tmgs_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on tmgs_pkg for the field widths.
`default_nettype none
interface tmgs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tmgs_pkg::CFG_IDX_W-1:0]  index;
  logic [tmgs_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/topic_model_gibbs_sampler.sv
// Collapsed Gibbs sampler for topic models, one token per word.
// Depends on tmgs_pkg and the interfaces tmgs_in_if, tmgs_out_if, tmgs_cfg_if.
//
// Usage: in_ch carries one token per word; mode 0 counts it under old_topic,
// mode 1 removes it from old_topic, draws a new topic from the count-based
// weights and counts it there. out_ch returns one word per token: the new
// topic and an error flag. cfg_ch writes topic_count, vocabulary_size, alpha
// and beta; it is always ready, and the user is to write it while the block
// is idle, which the block itself does not enforce. An add reads and writes
// its counters, then loads the result word; a rejected token goes straight
// to the result word. In a resample each of the K topics in use costs two
// 24-step divisions on the one shared restoring divider plus one pass
// through the shared 24x24 multiplier, and the search reads the prefix
// memory one topic at a time up to the pick. A quotient that saturates
// skips its steps. One token is in work at a time; in_ch.ready is high only
// while idle. After reset the count memories are swept to zero, one address
// a cycle, over WORDS*TOPICS = 524288 addresses, during which no token is
// taken. A stalled receiver holds the result in the output register; the block
// may accept and process the next token, then waits before delivering it.
`default_nettype none
module topic_model_gibbs_sampler (
  input  wire logic clk,
  input  wire logic rst_n,
  tmgs_in_if.sink   in_ch,
  tmgs_out_if.source out_ch,
  tmgs_cfg_if.sink  cfg_ch
);
  import tmgs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADJ_RD, S_ADJ_WR, S_VB, S_KA, S_W_RD, S_DIV_INIT, S_DIV,
    S_W_MUL, S_W_ACC, S_U_LO, S_U_HI, S_S_RD, S_S_CMP, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [7:0]            topic_count_r;
  logic [12:0]           vocab_r;
  logic [CFG_DATA_W-1:0] alpha_r, beta_r;

  // Token context.
  logic [DOC_W-1:0]   d_r;
  logic [WORD_W-1:0]  w_r;
  logic [15:0]        rnd_r;
  logic [TOPIC_W-1:0] adj_t_r, idx_r, pick_r;
  logic [TOPIC_W:0]   k_r;
  logic               add_r, err_r;
  logic [WT_AW-1:0]   clr_r;
  logic [COUNT_BITS-1:0] dl_r;
  logic [DEN_W-1:0]   vbeta_r, kalpha_r;

  // Shared divider and multiplier state.
  logic [DEN_W:0]     rem_r;
  logic [DEN_W-1:0]   den_r;
  logic [Q_BITS-1:0]  quo_r, q1_r;
  logic [4:0]         dcnt_r;
  logic               sel_r;
  logic [W_BITS-1:0]  prod_r, acc_r, u_r, plo_r;

  logic               out_valid_r, out_err_r;
  logic [6:0]         out_topic_r;

  // Memories.
  logic [COUNT_BITS-1:0] wt_mem [WORDS*TOPICS];
  logic [COUNT_BITS-1:0] dt_mem [DOCS*TOPICS];
  logic [TOT_BITS-1:0]   tt_mem [TOPICS];
  logic [COUNT_BITS-1:0] dl_mem [DOCS];
  logic [W_BITS-1:0]     pf_mem [TOPICS];
  logic [COUNT_BITS-1:0] wt_q, dt_q, dl_q;
  logic [TOT_BITS-1:0]   tt_q;
  logic [W_BITS-1:0]     pf_q;

  logic [TOPIC_W-1:0] tsel;
  logic [WT_AW-1:0]   wt_addr;
  logic [DT_AW-1:0]   dt_addr;
  logic [TOPIC_W-1:0] tt_addr;
  logic [DOC_W-1:0]   dl_addr;
  logic               clr_we, adj_we;
  logic               clr_dt, clr_tt, clr_dl;
  logic [COUNT_BITS-1:0] wt_new, dt_new, dl_new;
  logic [TOT_BITS-1:0]   tt_new;
  logic               adj_err;

  function automatic logic [12:0] vocab_eff(input logic [12:0] v);
    if (v == '0) return 13'd1;
    if (32'(v) > WORDS) return 13'(WORDS);
    return v;
  endfunction

  always_comb begin
    tsel    = (state_r == S_ADJ_RD || state_r == S_ADJ_WR) ? adj_t_r : idx_r;
    clr_we  = (state_r == S_CLEAR);
    adj_we  = (state_r == S_ADJ_WR);
    clr_dt  = 32'(clr_r) < DOCS * TOPICS;
    clr_tt  = 32'(clr_r) < TOPICS;
    clr_dl  = 32'(clr_r) < DOCS;
    wt_addr = clr_we ? clr_r : {w_r, tsel};
    dt_addr = clr_we ? clr_r[DT_AW-1:0] : {d_r, tsel};
    tt_addr = clr_we ? clr_r[TOPIC_W-1:0] : tsel;
    dl_addr = clr_we ? clr_r[DOC_W-1:0] : d_r;
  end

  // Saturating count update for the token's four counters.
  always_comb begin
    adj_err = 1'b0;
    if (add_r) begin
      if (wt_q == CNT_MAX) begin wt_new = wt_q; adj_err = 1'b1; end
      else wt_new = wt_q + 1'b1;
      if (dt_q == CNT_MAX) begin dt_new = dt_q; adj_err = 1'b1; end
      else dt_new = dt_q + 1'b1;
      if (tt_q == TOT_MAX) begin tt_new = tt_q; adj_err = 1'b1; end
      else tt_new = tt_q + 1'b1;
      if (dl_q == CNT_MAX) begin dl_new = dl_q; adj_err = 1'b1; end
      else dl_new = dl_q + 1'b1;
    end else begin
      if (wt_q == '0) begin wt_new = wt_q; adj_err = 1'b1; end
      else wt_new = wt_q - 1'b1;
      if (dt_q == '0) begin dt_new = dt_q; adj_err = 1'b1; end
      else dt_new = dt_q - 1'b1;
      if (tt_q == '0) begin tt_new = tt_q; adj_err = 1'b1; end
      else tt_new = tt_q - 1'b1;
      if (dl_q == '0) begin dl_new = dl_q; adj_err = 1'b1; end
      else dl_new = dl_q - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we || adj_we) wt_mem[wt_addr] <= clr_we ? '0 : wt_new;
    wt_q <= wt_mem[wt_addr];
  end
  always_ff @(posedge clk) begin
    if ((clr_we && clr_dt) || adj_we) dt_mem[dt_addr] <= clr_we ? '0 : dt_new;
    dt_q <= dt_mem[dt_addr];
  end
  always_ff @(posedge clk) begin
    if ((clr_we && clr_tt) || adj_we) tt_mem[tt_addr] <= clr_we ? '0 : tt_new;
    tt_q <= tt_mem[tt_addr];
  end
  always_ff @(posedge clk) begin
    if ((clr_we && clr_dl) || adj_we) dl_mem[dl_addr] <= clr_we ? '0 : dl_new;
    dl_q <= dl_mem[dl_addr];
  end

  // Prefix sums: written during the weight pass, read during the search.
  logic [W_BITS:0]   acc_sum;
  logic [W_BITS-1:0] acc_sat;
  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, prod_r};
    acc_sat = acc_sum[W_BITS] ? W_MAX : acc_sum[W_BITS-1:0];
  end
  always_ff @(posedge clk) begin
    if (state_r == S_W_ACC) pf_mem[idx_r] <= acc_sat;
    pf_q <= pf_mem[idx_r];
  end

  // Shared 24x24 multiplier.
  logic [Q_BITS-1:0] mul_a, mul_b;
  logic [W_BITS-1:0] mul_p;
  always_comb begin
    unique case (state_r)
      S_VB:    begin mul_a = Q_BITS'(vocab_eff(vocab_r)); mul_b = Q_BITS'(beta_r); end
      S_KA:    begin mul_a = Q_BITS'(k_r);                mul_b = Q_BITS'(alpha_r); end
      S_U_LO:  begin mul_a = Q_BITS'(rnd_r);              mul_b = acc_r[Q_BITS-1:0]; end
      S_U_HI:  begin mul_a = Q_BITS'(rnd_r);              mul_b = acc_r[W_BITS-1:Q_BITS]; end
      default: begin mul_a = q1_r;                        mul_b = quo_r; end
    endcase
    mul_p = W_BITS'(mul_a) * W_BITS'(mul_b);
  end

  // Divider operands and step for the two quotients of the current topic; the draw product sum.
  logic [DEN_W-1:0] num_sel, den_sel;
  logic [DEN_W:0]   rem_sh;
  logic             step_ge;
  logic [W_BITS+Q_BITS-1:0] u_full;
  always_comb begin
    if (!sel_r) begin
      num_sel = DEN_W'({wt_q, 16'b0}) + DEN_W'(beta_r);
      den_sel = DEN_W'({tt_q, 16'b0}) + vbeta_r;
    end else begin
      num_sel = DEN_W'({dt_q, 16'b0}) + DEN_W'(alpha_r);
      den_sel = DEN_W'({dl_r, 16'b0}) + kalpha_r;
    end
    rem_sh  = {rem_r[DEN_W-1:0], 1'b0};
    step_ge = rem_sh >= {1'b0, den_r};
    u_full  = {mul_p, {Q_BITS{1'b0}}} + (W_BITS+Q_BITS)'(plo_r);
  end

  // Input validity check and clamped topic count.
  logic [TOPIC_W:0] k_in;
  logic             bad_in;
  always_comb begin
    if (topic_count_r == '0) k_in = (TOPIC_W+1)'(1);
    else if (32'(topic_count_r) > TOPICS) k_in = (TOPIC_W+1)'(TOPICS);
    else k_in = (TOPIC_W+1)'(topic_count_r);
    bad_in = (32'(in_ch.doc_index) >= DOCS)
          || ({1'b0, in_ch.word_index} >= vocab_eff(vocab_r))
          || ({1'b0, in_ch.old_topic} >= k_in);
  end

  logic [TOPIC_W-1:0] k_last;
  assign k_last = TOPIC_W'(k_r - 1'b1);

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_topic = out_topic_r;
  assign out_ch.count_error = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
      topic_count_r <= 8'd100;
      vocab_r       <= 13'd4096;
      alpha_r       <= 20'd32768;
      beta_r        <= 20'd655;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_TOPIC_COUNT: topic_count_r <= cfg_ch.data[7:0];
          REG_VOCAB_SIZE:  vocab_r       <= cfg_ch.data[12:0];
          REG_ALPHA:       alpha_r       <= cfg_ch.data;
          REG_BETA:        beta_r        <= cfg_ch.data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            d_r     <= in_ch.doc_index;
            w_r     <= in_ch.word_index;
            adj_t_r <= in_ch.old_topic;
            pick_r  <= in_ch.old_topic;
            rnd_r   <= in_ch.random_fraction;
            add_r   <= !in_ch.mode;
            k_r     <= k_in;
            err_r   <= bad_in;
            state_r <= bad_in ? S_OUT : S_ADJ_RD;
          end
        end
        S_ADJ_RD: state_r <= S_ADJ_WR;
        S_ADJ_WR: begin
          err_r <= err_r | adj_err;
          dl_r  <= dl_new;
          if (add_r) begin
            pick_r  <= adj_t_r;
            state_r <= S_OUT;
          end else begin
            state_r <= S_VB;
          end
        end
        S_VB: begin
          vbeta_r <= DEN_W'(mul_p);
          state_r <= S_KA;
        end
        S_KA: begin
          kalpha_r <= DEN_W'(mul_p);
          idx_r    <= '0;
          acc_r    <= '0;
          state_r  <= S_W_RD;
        end
        S_W_RD: begin
          sel_r   <= 1'b0;
          state_r <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          rem_r  <= {1'b0, num_sel};
          den_r  <= den_sel;
          dcnt_r <= '0;
          // A zero divisor with a nonzero numerator and quotients of one or more saturate at once; 0/0 gives zero.
          if (den_sel == '0 || num_sel >= den_sel) begin
            if (!sel_r) begin
              q1_r  <= (num_sel == '0) ? '0 : Q_MAX;
              quo_r <= '0;
              sel_r <= 1'b1;
            end else begin
              quo_r   <= (num_sel == '0) ? '0 : Q_MAX;
              state_r <= S_W_MUL;
            end
          end else begin
            quo_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= step_ge ? rem_sh - {1'b0, den_r} : rem_sh;
          quo_r  <= {quo_r[Q_BITS-2:0], step_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (32'(dcnt_r) == Q_BITS - 1) begin
            if (!sel_r) begin
              q1_r    <= {quo_r[Q_BITS-2:0], step_ge};
              sel_r   <= 1'b1;
              state_r <= S_DIV_INIT;
            end else begin
              state_r <= S_W_MUL;
            end
          end
        end
        S_W_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_W_ACC;
        end
        S_W_ACC: begin
          acc_r <= acc_sat;
          if (idx_r == k_last) begin
            state_r <= S_U_LO;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_W_RD;
          end
        end
        S_U_LO: begin
          plo_r   <= mul_p;
          state_r <= S_U_HI;
        end
        S_U_HI: begin
          u_r     <= u_full[W_BITS+FRAC-1:FRAC];
          idx_r   <= '0;
          state_r <= S_S_RD;
        end
        S_S_RD: state_r <= S_S_CMP;
        S_S_CMP: begin
          if (pf_q > u_r || idx_r == k_last) begin
            adj_t_r <= idx_r;
            add_r   <= 1'b1;
            state_r <= S_ADJ_RD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_topic_r <= 7'(pick_r);
            out_err_r   <= err_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("token taken during the clearing sweep");

  a_prefix_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_ACC) |=> (acc_r >= $past(acc_r)))
    else $error("prefix sum decreased");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (32'(dcnt_r) < Q_BITS))
    else $error("divider ran past its last step");

  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_S_CMP) |-> ({1'b0, idx_r} < k_r))
    else $error("search index beyond topics in use");
endmodule
`default_nettype wire
